// ===== hdl/next_fit_free_block_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the next-fit free-block allocator
// Shorthand for clocked implication checks on clk_i, masked during reset.
// ----------------------------------------------------------------------------
`ifndef NEXT_FIT_FREE_BLOCK_ALLOCATOR_MACROS_SVH
`define NEXT_FIT_FREE_BLOCK_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define NFFBA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("nffba check failed");

// next-cycle implication
`define NFFBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("nffba check failed");

`endif

// ===== hdl/nffba_pkg.sv =====
// ----------------------------------------------------------------------------
// nffba_pkg
// Shared constants, codes and state type of the next-fit free-block allocator.
// ----------------------------------------------------------------------------
package nffba_pkg;

  localparam int TableEntries = 8;
  localparam int AddrWidth    = 16;
  localparam int FieldWidth   = 16;

  // action codes
  localparam logic [1:0] ACT_INIT  = 2'd0;
  localparam logic [1:0] ACT_ALLOC = 2'd1;
  localparam logic [1:0] ACT_FREE  = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_BAD   = 2'd3;

  // configuration register indexes
  localparam logic CFG_ARENA_BASE = 1'b0;
  localparam logic CFG_ARENA_SIZE = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_RD,
    S_A_EV,
    S_F_RD,
    S_F_EV,
    S_F_DEC,
    S_SD_RD,
    S_SD_WR,
    S_SU_RD,
    S_SU_WR,
    S_DONE
  } state_e;

endpackage

// ===== hdl/next_fit_free_block_allocator.sv =====
// Allocate probes entries from the rover onward; free reads entries in address order
//   until one starts above the freed address or the scan runs off the end. Closing or
//   opening a gap moves the entries one at a time.
// One item at a time: the single read port of the table memory sets the pace.
// Reset clears control state, the entry count and the rover; no clearing pass.
// ----------------------------------------------------------------------------
// next_fit_free_block_allocator
// Next-fit allocator over an address-sorted free-block table with coalescing.
// ----------------------------------------------------------------------------
module next_fit_free_block_allocator #(
  parameter int TABLE_ENTRIES = nffba_pkg::TableEntries,
  parameter int ADDR_WIDTH    = nffba_pkg::AddrWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [31:0] s_tdata_i,   // req_size [15:0], req_addr [31:16]
  input  logic [1:0]  s_tuser_i,   // action [1:0]
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [23:0] m_tdata_o,   // grant_addr [15:0], status [17:16], zero [23:18]
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int AW = ADDR_WIDTH;
  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int EW = 34;
  localparam int FW = nffba_pkg::FieldWidth;
  localparam logic [EW-1:0] Mask = EW'((64'd1 << AW) - 64'd1);
  localparam logic [CW-1:0] Full = CW'(TABLE_ENTRIES);

  nffba_pkg::state_e state_q, state_d;

  logic [FW-1:0]   base_q, asize_q;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [IW-1:0]   rover_q, rover_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [CW-1:0]   step_q, step_d;
  logic [FW-1:0]   rsize_q, rsize_d;
  logic [FW-1:0]   raddr_q, raddr_d;
  logic [AW-1:0]   ps_q, ps_d, pl_q, pl_d;
  logic [AW-1:0]   us_q, us_d, ul_q, ul_d;
  logic            up_q, up_d;
  logic [FW-1:0]   grant_q, grant_d;
  logic [1:0]      status_q, status_d;
  logic            out_valid_q;
  logic [23:0]     out_data_q;

  logic            we;
  logic [IW-1:0]   waddr, rd_addr;
  logic [2*AW-1:0] wdata, rdata;
  logic [AW-1:0]   rd_start, rd_len;

  logic [EW-1:0]   base_m, end_sum, arena_end;
  logic [EW-1:0]   in_end, f_end, low_end;
  logic            slot_free;

  nffba_mem #(.Depth(TABLE_ENTRIES), .Width(2 * AW)) u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(rd_addr),
    .rdata_o(rdata)
  );

  assign rd_start = rdata[AW-1:0];
  assign rd_len   = rdata[2*AW-1:AW];

  assign base_m    = EW'(base_q) & Mask;
  assign end_sum   = base_m + EW'(asize_q);
  assign arena_end = (end_sum > Mask) ? Mask : end_sum;
  assign in_end    = EW'(s_tdata_i[31:16]) + EW'(s_tdata_i[15:0]);
  assign f_end     = EW'(raddr_q) + EW'(rsize_q);
  assign low_end   = EW'(ps_q) + EW'(pl_q);
  assign slot_free = !out_valid_q || m_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      asize_q <= 16'hFFFF;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        nffba_pkg::CFG_ARENA_BASE: base_q  <= cfg_wdata_i;
        nffba_pkg::CFG_ARENA_SIZE: asize_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nffba_pkg::S_IDLE;
      cnt_q   <= '0;
      rover_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rover_q <= rover_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    step_q   <= step_d;
    rsize_q  <= rsize_d;
    raddr_q  <= raddr_d;
    ps_q     <= ps_d;
    pl_q     <= pl_d;
    us_q     <= us_d;
    ul_q     <= ul_d;
    up_q     <= up_d;
    grant_q  <= grant_d;
    status_q <= status_d;
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    rover_d  = rover_q;
    idx_d    = idx_q;
    step_d   = step_q;
    rsize_d  = rsize_q;
    raddr_d  = raddr_q;
    ps_d     = ps_q;
    pl_d     = pl_q;
    us_d     = us_q;
    ul_d     = ul_q;
    up_d     = up_q;
    grant_d  = grant_q;
    status_d = status_q;
    we       = 1'b0;
    waddr    = idx_q[IW-1:0];
    wdata    = '0;
    rd_addr  = idx_q[IW-1:0];
    case (state_q)
      nffba_pkg::S_IDLE: begin
        if (s_tvalid_i) begin
          rsize_d  = s_tdata_i[15:0];
          raddr_d  = s_tdata_i[31:16];
          grant_d  = '0;
          status_d = nffba_pkg::ST_OK;
          state_d  = nffba_pkg::S_DONE;
          case (s_tuser_i)
            nffba_pkg::ACT_INIT: begin
              we      = 1'b1;
              waddr   = '0;
              wdata   = {AW'(arena_end - base_m), base_m[AW-1:0]};
              cnt_d   = (arena_end > base_m) ? CW'(1) : '0;
              rover_d = '0;
            end
            nffba_pkg::ACT_ALLOC: begin
              if (s_tdata_i[15:0] == '0) begin
                status_d = nffba_pkg::ST_BAD;
              end else if (cnt_q == '0) begin
                status_d = nffba_pkg::ST_NOFIT;
              end else begin
                idx_d   = (CW'(rover_q) < cnt_q) ? CW'(rover_q) : '0;
                step_d  = '0;
                state_d = nffba_pkg::S_A_RD;
              end
            end
            nffba_pkg::ACT_FREE: begin
              if (s_tdata_i[15:0] == '0 || EW'(s_tdata_i[31:16]) < base_m ||
                  in_end > arena_end) begin
                status_d = nffba_pkg::ST_BAD;
              end else begin
                idx_d   = '0;
                up_d    = 1'b0;
                state_d = nffba_pkg::S_F_RD;
              end
            end
            default: status_d = nffba_pkg::ST_BAD;
          endcase
        end
      end
      nffba_pkg::S_A_RD: begin
        state_d = nffba_pkg::S_A_EV;
      end
      nffba_pkg::S_A_EV: begin
        if (EW'(rd_len) >= EW'(rsize_q)) begin
          we      = 1'b1;
          wdata   = {AW'(EW'(rd_len) - EW'(rsize_q)),
                     AW'(EW'(rd_start) + EW'(rsize_q))};
          grant_d = FW'(rd_start);
          rover_d = idx_q[IW-1:0];
          if (EW'(rd_len) == EW'(rsize_q)) begin
            // block used up: close the gap
            if (idx_q >= cnt_q - CW'(1)) begin
              rover_d = '0;
            end
            state_d = nffba_pkg::S_SD_RD;
          end else begin
            state_d = nffba_pkg::S_DONE;
          end
        end else if (step_q + CW'(1) == cnt_q) begin
          status_d = nffba_pkg::ST_NOFIT;
          state_d  = nffba_pkg::S_DONE;
        end else begin
          step_d  = step_q + CW'(1);
          idx_d   = (idx_q + CW'(1) == cnt_q) ? '0 : idx_q + CW'(1);
          state_d = nffba_pkg::S_A_RD;
        end
      end
      nffba_pkg::S_F_RD: begin
        if (idx_q == cnt_q) begin
          state_d = nffba_pkg::S_F_DEC;
        end else begin
          state_d = nffba_pkg::S_F_EV;
        end
      end
      nffba_pkg::S_F_EV: begin
        if (EW'(rd_start) <= EW'(raddr_q)) begin
          ps_d    = rd_start;
          pl_d    = rd_len;
          idx_d   = idx_q + CW'(1);
          state_d = nffba_pkg::S_F_RD;
        end else begin
          us_d    = rd_start;
          ul_d    = rd_len;
          up_d    = 1'b1;
          state_d = nffba_pkg::S_F_DEC;
        end
      end
      nffba_pkg::S_F_DEC: begin
        state_d = nffba_pkg::S_DONE;
        if ((idx_q != '0 && low_end > EW'(raddr_q)) || (up_q && f_end > EW'(us_q))) begin
          status_d = nffba_pkg::ST_BAD;
        end else if (idx_q != '0 && low_end == EW'(raddr_q)) begin
          we    = 1'b1;
          waddr = IW'(idx_q - CW'(1));
          if (up_q && f_end == EW'(us_q)) begin
            wdata = {AW'(EW'(pl_q) + EW'(rsize_q) + EW'(ul_q)), ps_q};
            if (CW'(rover_q) >= idx_q) begin
              rover_d = rover_q - IW'(1);
            end
            state_d = nffba_pkg::S_SD_RD;
          end else begin
            wdata = {AW'(EW'(pl_q) + EW'(rsize_q)), ps_q};
          end
        end else if (up_q && f_end == EW'(us_q)) begin
          we    = 1'b1;
          wdata = {AW'(EW'(ul_q) + EW'(rsize_q)), AW'(raddr_q)};
        end else if (cnt_q == Full) begin
          status_d = nffba_pkg::ST_FULL;
        end else begin
          if (CW'(rover_q) >= idx_q && CW'(rover_q) < cnt_q) begin
            rover_d = rover_q + IW'(1);
          end
          step_d  = cnt_q;
          state_d = nffba_pkg::S_SU_RD;
        end
      end
      // shift down: entries idx+1..cnt-1 move one place lower
      nffba_pkg::S_SD_RD: begin
        rd_addr = IW'(idx_q + CW'(1));
        if (idx_q + CW'(1) >= cnt_q) begin
          cnt_d   = cnt_q - CW'(1);
          state_d = nffba_pkg::S_DONE;
        end else begin
          state_d = nffba_pkg::S_SD_WR;
        end
      end
      nffba_pkg::S_SD_WR: begin
        we      = 1'b1;
        wdata   = rdata;
        idx_d   = idx_q + CW'(1);
        state_d = nffba_pkg::S_SD_RD;
      end
      // shift up: step walks from cnt down to idx, then insert at idx
      nffba_pkg::S_SU_RD: begin
        rd_addr = IW'(step_q - CW'(1));
        if (step_q == idx_q) begin
          we      = 1'b1;
          wdata   = {AW'(rsize_q), AW'(raddr_q)};
          cnt_d   = cnt_q + CW'(1);
          state_d = nffba_pkg::S_DONE;
        end else begin
          state_d = nffba_pkg::S_SU_WR;
        end
      end
      nffba_pkg::S_SU_WR: begin
        we      = 1'b1;
        waddr   = step_q[IW-1:0];
        wdata   = rdata;
        step_d  = step_q - CW'(1);
        state_d = nffba_pkg::S_SU_RD;
      end
      nffba_pkg::S_DONE: begin
        if (slot_free) begin
          state_d = nffba_pkg::S_IDLE;
        end
      end
      default: state_d = nffba_pkg::S_IDLE;
    endcase
  end

  // output register: load the finished item when the slot is free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == nffba_pkg::S_DONE && slot_free) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == nffba_pkg::S_DONE && slot_free) begin
      out_data_q <= {6'd0, status_q,
                     (status_q == nffba_pkg::ST_OK) ? grant_q : {FW{1'b0}}};
    end
  end

  assign s_tready_o = (state_q == nffba_pkg::S_IDLE);
  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;

  `include "next_fit_free_block_allocator_macros.svh"

  `NFFBA_ASSERT_SAME(a_cnt_range, 1'b1, cnt_q <= Full)
  `NFFBA_ASSERT_NEXT(a_accept_busy, s_tvalid_i && s_tready_o, state_q != nffba_pkg::S_IDLE)
  `NFFBA_ASSERT_SAME(a_grant_ok, m_tvalid_o && m_tdata_o[15:0] != 16'd0, m_tdata_o[17:16] == nffba_pkg::ST_OK)

endmodule

// ===== hdl/nffba_mem.sv =====
// ----------------------------------------------------------------------------
// nffba_mem
// Free-block table storage: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module nffba_mem #(
  parameter int Depth = nffba_pkg::TableEntries,
  parameter int Width = 2 * nffba_pkg::AddrWidth
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/next_fit_free_block_allocator_test.sv =====
// ----------------------------------------------------------------------------
// Next-fit free-block allocator testbench
// Drives init, allocate and free items over the stream port, predicts each
// grant and status with a table model kept in step, and checks every result.
// ----------------------------------------------------------------------------
module next_fit_free_block_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NE = nffba_pkg::TableEntries;
  localparam int AMAX = (1 << nffba_pkg::AddrWidth) - 1;
  localparam logic [1:0] ActUnknown = 2'd3;

  typedef struct packed {
    logic [15:0] grant;
    logic [1:0]  status;
  } grant_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  logic [31:0] s_tdata_i = '0;
  logic [1:0]  s_tuser_i = '0;
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  logic [23:0] m_tdata_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  next_fit_free_block_allocator dut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // predictor state
  int unsigned base_q = 0;
  int unsigned size_q = 65535;
  int unsigned fb_start[NE];
  int unsigned fb_len[NE];
  int unsigned rover_q = 0;

  grant_t expected_grants[$];
  int     errors = 0;
  bit     recv_idle_en = 1'b1;
  bit     send_idle_en = 1'b1;
  int     hold_off = 0;

  function automatic int unsigned live_entries();
    int unsigned n;
    n = 0;
    while (n < NE && fb_len[n] != 0) n++;
    return n;
  endfunction

  function automatic int unsigned arena_limit();
    int unsigned e;
    e = base_q + size_q;
    if (e > AMAX) e = AMAX;
    return e;
  endfunction

  function automatic void drop_entry(int unsigned i, int unsigned n);
    for (int unsigned k = i; k + 1 < n; k++) begin
      fb_start[k] = fb_start[k+1];
      fb_len[k] = fb_len[k+1];
    end
    if (n > 0) begin
      fb_start[n-1] = 0;
      fb_len[n-1] = 0;
    end
  endfunction

  function automatic grant_t predict_grant(logic [1:0] act, int unsigned sz,
                                           int unsigned ad);
    grant_t r;
    int unsigned n, first, i, e, idx;
    bit lo, up;
    r = '0;
    n = live_entries();
    case (act)
      nffba_pkg::ACT_INIT: begin
        for (int k = 0; k < NE; k++) begin
          fb_start[k] = 0;
          fb_len[k] = 0;
        end
        e = arena_limit();
        if (e > base_q) begin
          fb_start[0] = base_q;
          fb_len[0] = e - base_q;
        end
        rover_q = 0;
        r.status = nffba_pkg::ST_OK;
      end
      nffba_pkg::ACT_ALLOC: begin
        if (sz == 0) begin
          r.status = nffba_pkg::ST_BAD;
        end else begin
          r.status = nffba_pkg::ST_NOFIT;
          first = (rover_q < n) ? rover_q : 0;
          for (int unsigned s = 0; s < n; s++) begin
            i = first + s;
            if (i >= n) i -= n;
            if (fb_len[i] >= sz) begin
              r.grant = 16'(fb_start[i]);
              r.status = nffba_pkg::ST_OK;
              fb_start[i] = (fb_start[i] + sz) & AMAX;
              fb_len[i] -= sz;
              if (fb_len[i] == 0) begin
                drop_entry(i, n);
                n--;
              end
              rover_q = (i < n) ? i : 0;
              break;
            end
          end
        end
      end
      nffba_pkg::ACT_FREE: begin
        e = ad + sz;
        idx = 0;
        if (sz == 0 || ad < base_q || e > arena_limit())
          return '{16'd0, nffba_pkg::ST_BAD};
        while (idx < n && fb_start[idx] <= ad) idx++;
        if (idx > 0 && fb_start[idx-1] + fb_len[idx-1] > ad)
          return '{16'd0, nffba_pkg::ST_BAD};
        if (idx < n && e > fb_start[idx]) return '{16'd0, nffba_pkg::ST_BAD};
        lo = idx > 0 && fb_start[idx-1] + fb_len[idx-1] == ad;
        up = idx < n && e == fb_start[idx];
        r.status = nffba_pkg::ST_OK;
        if (lo && up) begin
          fb_len[idx-1] += sz + fb_len[idx];
          drop_entry(idx, n);
          if (rover_q >= idx) rover_q--;
        end else if (lo) begin
          fb_len[idx-1] += sz;
        end else if (up) begin
          fb_start[idx] = ad;
          fb_len[idx] += sz;
        end else if (n >= NE) begin
          r.status = nffba_pkg::ST_FULL;
        end else begin
          for (int unsigned k = n; k > idx; k--) begin
            fb_start[k] = fb_start[k-1];
            fb_len[k] = fb_len[k-1];
          end
          fb_start[idx] = ad;
          fb_len[idx] = sz;
          if (rover_q >= idx && rover_q < n) rover_q++;
        end
      end
      default: r.status = nffba_pkg::ST_BAD;
    endcase
    if (r.status != nffba_pkg::ST_OK) r.grant = 0;
    return r;
  endfunction

  // send one item; predict at acceptance; valid stays up until the next change
  task automatic send_request(logic [1:0] act, logic [15:0] sz, logic [15:0] ad);
    if (send_idle_en && $urandom_range(0, 5) == 0) begin
      s_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i <= act;
    s_tdata_i <= {ad, sz};
    do @(posedge clk_i); while (!s_tready_o);
    expected_grants.push_back(predict_grant(act, 32'(sz), 32'(ad)));
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_tvalid_i <= 1'b0;
    while (expected_grants.size() != 0) @(negedge clk_i);
    repeat (4 * NE + 8) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    if (idx == nffba_pkg::CFG_ARENA_BASE) base_q = 32'(val); else size_q = 32'(val);
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready_i <= 1'b0;
    end else begin
      m_tready_i <= !(recv_idle_en && $urandom_range(0, 4) == 0);
    end
  end

  always @(posedge clk_i) begin
    grant_t want, got;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      got = {m_tdata_o[15:0], m_tdata_o[17:16]};
      if (expected_grants.size() == 0) begin
        $display("%0t unexpected result %h", $time, m_tdata_o);
        errors++;
      end else begin
        want = expected_grants.pop_front();
        if (got.grant !== want.grant || got.status !== want.status
            || m_tdata_o[23:18] !== 6'd0) begin
          $display("%0t mismatch: expected grant %h status %0d, got grant %h status %0d",
                   $time, want.grant, want.status, got.grant, got.status);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_request(nffba_pkg::ACT_ALLOC, 16'd5, 16'd0);         // alloc before init
    send_request(nffba_pkg::ACT_FREE, 16'd5, 16'd0);
    send_request(nffba_pkg::ACT_INIT, 16'hffff, 16'hffff);
    send_request(nffba_pkg::ACT_ALLOC, 16'd0, 16'd0);         // zero size
    send_request(nffba_pkg::ACT_FREE, 16'd0, 16'd10);
    send_request(ActUnknown, 16'd1, 16'd1);                   // unknown action
    send_request(nffba_pkg::ACT_ALLOC, 16'd100, 16'd0);
    send_request(nffba_pkg::ACT_ALLOC, 16'd100, 16'd0);
    send_request(nffba_pkg::ACT_ALLOC, 16'hffff, 16'd0);      // no fit
    send_request(nffba_pkg::ACT_FREE, 16'd50, 16'd0);         // insert
    send_request(nffba_pkg::ACT_FREE, 16'd10, 16'd60);        // insert
    send_request(nffba_pkg::ACT_FREE, 16'd10, 16'd50);        // merge both sides
    send_request(nffba_pkg::ACT_FREE, 16'd20, 16'd40);        // overlap
    send_request(nffba_pkg::ACT_FREE, 16'd30, 16'd70);        // low merge
    send_request(nffba_pkg::ACT_FREE, 16'd100, 16'd100);      // merge both sides -> one block
    send_request(nffba_pkg::ACT_FREE, 16'd2, 16'hfffe);       // past arena end
    send_request(nffba_pkg::ACT_ALLOC, 16'hfffe, 16'd0);      // all but one unit of the block
    send_request(nffba_pkg::ACT_ALLOC, 16'd1, 16'd0);
    drain_results();
  endtask

  task automatic test_table_full();
    write_reg(nffba_pkg::CFG_ARENA_BASE, 16'd16);
    write_reg(nffba_pkg::CFG_ARENA_SIZE, 16'd64);
    send_request(nffba_pkg::ACT_INIT, 16'd0, 16'd0);
    send_request(nffba_pkg::ACT_ALLOC, 16'd64, 16'd0);
    for (int k = 0; k < NE + 2; k++) begin
      send_request(nffba_pkg::ACT_FREE, 16'd1, 16'(16 + 2 * k));
    end
    send_request(nffba_pkg::ACT_FREE, 16'd1, 16'd15);         // below base
    drain_results();
    write_reg(nffba_pkg::CFG_ARENA_BASE, 16'hffff);           // empty arena
    send_request(nffba_pkg::ACT_INIT, 16'd0, 16'd0);
    send_request(nffba_pkg::ACT_ALLOC, 16'd1, 16'd0);
    drain_results();
  endtask

  task automatic random_phase(int items, int unsigned b, int unsigned sz);
    int unsigned a, s, span;
    logic [1:0] act;
    write_reg(nffba_pkg::CFG_ARENA_BASE, 16'(b));
    write_reg(nffba_pkg::CFG_ARENA_SIZE, 16'(sz));
    send_request(nffba_pkg::ACT_INIT, 16'($urandom), 16'($urandom));
    span = sz < 256 ? sz : 256;
    for (int k = 0; k < items; k++) begin
      case ($urandom_range(0, 19))
        0: act = nffba_pkg::ACT_INIT;
        1: act = ActUnknown;
        2, 3, 4, 5, 6, 7, 8: act = nffba_pkg::ACT_ALLOC;
        default: act = nffba_pkg::ACT_FREE;
      endcase
      if ($urandom_range(0, 15) == 0) begin
        s = $urandom_range(0, 65535);
        a = $urandom_range(0, 65535);
      end else begin
        s = $urandom_range(1, span / 4 + 1);
        a = b + $urandom_range(0, sz);
      end
      send_request(act, 16'(s), 16'(a));
    end
    drain_results();
  endtask

  task automatic test_backpressure();
    hold_off = 60;
    for (int k = 0; k < 12; k++) send_request(nffba_pkg::ACT_ALLOC, 16'd3, 16'($urandom));
    drain_results();
  endtask

  initial begin
    for (int k = 0; k < NE; k++) begin
      fb_start[k] = 0;
      fb_len[k] = 0;
    end
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_table_full();
    random_phase(500, 100, 200);
    random_phase(400, 0, 65535);
    test_backpressure();
    random_phase(300, 65000, 535);
    recv_idle_en = 1'b0;
    send_idle_en = 1'b0;
    random_phase(400, 1000, 96);
    if (errors == 0) begin
      $display("[next_fit_free_block_allocator] OK");
    end else begin
      $display("[next_fit_free_block_allocator] ERROR");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("[next_fit_free_block_allocator] ERROR");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/nffba_pkg.sv
hdl/nffba_mem.sv
hdl/next_fit_free_block_allocator.sv
tb/next_fit_free_block_allocator_test.sv
